// File: hw/rtl/console_monitor_output_tracker_core_macros.svh
// Assertion macros shared by the console monitor output tracker RTL.
`ifndef CONSOLE_MONITOR_OUTPUT_TRACKER_CORE_MACROS_SVH
`define CONSOLE_MONITOR_OUTPUT_TRACKER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CMOT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cmot assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CMOT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cmot assertion failed");

`endif

// File: hw/rtl/cmot_pkg.sv
// Shared types and constants of the console monitor output tracker.
package cmot_pkg;

    // Width of the prompt and idle tick counters.
    localparam int TIMER_BITS = 24;
    localparam int TIMEOUT_W  = 24;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int ADDR_W     = 16;
    localparam int CMP_W      = (TIMER_BITS > TIMEOUT_W) ? TIMER_BITS : TIMEOUT_W;

    typedef logic [TIMER_BITS-1:0] timer_t;
    typedef logic [TIMEOUT_W-1:0]  timeout_t;
    typedef logic [CMP_W-1:0]      cmp_t;
    typedef logic [ADDR_W-1:0]     word_t;

    // Characters the console monitor echoes.
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_L      = 8'h4C;
    localparam logic [7:0] CH_E      = 8'h45;
    localparam logic [7:0] CH_D      = 8'h44;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;

    // Step applied to the address on a repeated deposit.
    localparam word_t ADDR_STEP = word_t'(2);

    // Configuration register reset values.
    localparam logic [7:0] SYNC_CHAR_RST = 8'd46;
    localparam timeout_t PROMPT_TO_RST   = timeout_t'(1000);
    localparam timeout_t IDLE_TO_RST     = timeout_t'(100);

    typedef enum logic [1:0] {
        KIND_CHAR     = 2'd0,
        KIND_TICK     = 2'd1,
        KIND_CMD_SENT = 2'd2,
        KIND_RESTART  = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_CHAR = 2'd0,
        CFG_PROMPT_TO = 2'd1,
        CFG_IDLE_TO   = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_LOAD  = 3'd1,
        CMD_EXAM  = 3'd2,
        CMD_DEP   = 3'd3,
        CMD_START = 3'd4
    } cmd_t;

    typedef enum logic [7:0] {
        PH_START            = 8'b0000_0001,
        PH_WAIT_SYNC        = 8'b0000_0010,
        PH_WAIT_INIT_PROMPT = 8'b0000_0100,
        PH_WAIT_PROMPT      = 8'b0000_1000,
        PH_READY            = 8'b0001_0000,
        PH_WAIT_RESP        = 8'b0010_0000,
        PH_PARSE_ADDR       = 8'b0100_0000,
        PH_PARSE_VAL        = 8'b1000_0000
    } phase_t;

    // Configuration seen by the tracker.
    typedef struct packed {
        logic [7:0] sync_char;
        timeout_t   prompt_timeout;
        timeout_t   idle_timeout;
    } cfg_t;

    // One result transaction.
    typedef struct packed {
        logic       char_ok;
        logic       send_sync;
        logic       timed_out;
        logic       ready_res;
        logic [2:0] last_command;
        word_t      last_address;
        logic       address_known;
        word_t      last_value;
    } result_t;

endpackage

// File: hw/rtl/console_monitor_output_tracker_core.sv
// Path: an accepted transaction is held in the input register, and its tracker update
// is then captured in the result register; a result register that is not drained holds it back.
// Throughput: one transaction per cycle while the result register drains, set by the single
// input register feeding the tracker update and the result register.
// Reset: rst_n is asynchronous and active low; it empties both registers, restores
// the configuration defaults and returns the tracker to its start phase.
module console_monitor_output_tracker_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [cmot_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cmot_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       kind,
    input  logic [7:0]                       rx_char,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             char_ok,
    output logic                             send_sync,
    output logic                             timed_out,
    output logic                             ready_res,
    output logic [2:0]                       last_command,
    output logic [15:0]                      last_address,
    output logic                             address_known,
    output logic [15:0]                      last_value
);

`include "console_monitor_output_tracker_core_macros.svh"

    cmot_pkg::cfg_t    cfg;
    cmot_pkg::result_t result_comb;
    cmot_pkg::result_t result_reg;
    logic              in_vld_reg, in_vld_next;
    logic              out_vld_reg, out_vld_next;
    logic [1:0]        kind_reg;
    logic [7:0]        rx_char_reg;
    logic              in_accept;
    logic              advance;

    cmot_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cmot_tracker u_tracker (
        .clk     (clk),
        .rst_n   (rst_n),
        .item_en (advance),
        .kind    (kind_reg),
        .rx_char (rx_char_reg),
        .cfg     (cfg),
        .result  (result_comb)
    );

    // A held transaction moves on when the result register is free or drains.
    assign advance   = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready  = !in_vld_reg || advance;
    assign in_accept = in_valid && in_ready;

    // Valid flags of the input and result registers.
    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_accept)
        begin
            in_vld_next = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (advance)
        begin
            out_vld_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            kind_reg    <= kind;
            rx_char_reg <= rx_char;
        end
        if (advance)
        begin
            result_reg <= result_comb;
        end
    end

    assign out_valid     = out_vld_reg;
    assign char_ok       = result_reg.char_ok;
    assign send_sync     = result_reg.send_sync;
    assign timed_out     = result_reg.timed_out;
    assign ready_res     = result_reg.ready_res;
    assign last_command  = result_reg.last_command;
    assign last_address  = result_reg.last_address;
    assign address_known = result_reg.address_known;
    assign last_value    = result_reg.last_value;

    // Checks on the tracker and the register stage.
    `CMOT_ASSERT_SAME(a_ready_no_flags, clk, rst_n, out_vld_reg && result_reg.ready_res, !result_reg.send_sync && !result_reg.timed_out)
    `CMOT_ASSERT_SAME(a_char_no_flags, clk, rst_n, out_vld_reg && result_reg.char_ok, !result_reg.send_sync && !result_reg.timed_out)
    `CMOT_ASSERT_SAME(a_unknown_addr_zero, clk, rst_n, out_vld_reg && !result_reg.address_known, result_reg.last_address == '0)
    `CMOT_ASSERT_NEXT(a_advance_fills_out, clk, rst_n, advance, out_vld_reg)

endmodule

// File: hw/rtl/cmot_cfg_regs.sv
// Configuration registers of the console monitor output tracker.
module cmot_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [cmot_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cmot_pkg::CFG_DATA_W-1:0]  cfg_data,
    output cmot_pkg::cfg_t                   cfg
);

    cmot_pkg::cfg_t cfg_reg;
    cmot_pkg::cfg_t cfg_next;

    // Decode the register index; unused indexes write nothing.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cmot_pkg::cfg_idx_t'(cfg_index))
                cmot_pkg::CFG_SYNC_CHAR: cfg_next.sync_char = cfg_data[7:0];
                cmot_pkg::CFG_PROMPT_TO:
                    cfg_next.prompt_timeout = cfg_data[cmot_pkg::TIMEOUT_W-1:0];
                cmot_pkg::CFG_IDLE_TO:
                    cfg_next.idle_timeout = cfg_data[cmot_pkg::TIMEOUT_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    // Register storage with reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_char      <= cmot_pkg::SYNC_CHAR_RST;
            cfg_reg.prompt_timeout <= cmot_pkg::PROMPT_TO_RST;
            cfg_reg.idle_timeout   <= cmot_pkg::IDLE_TO_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hw/rtl/cmot_tracker.sv
// Console state, tick timers and per-transaction update logic.
module cmot_tracker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_en,
    input  logic [1:0]           kind,
    input  logic [7:0]           rx_char,
    input  cmot_pkg::cfg_t       cfg,
    output cmot_pkg::result_t    result
);

    cmot_pkg::phase_t phase_reg, phase_next;
    cmot_pkg::cmd_t   cmd_reg, cmd_next;
    cmot_pkg::word_t  addr_reg, addr_next;
    logic             addr_vld_reg, addr_vld_next;
    cmot_pkg::word_t  value_reg, value_next;
    logic             digit_seen_reg, digit_seen_next;
    cmot_pkg::timer_t prompt_elapsed_reg, prompt_elapsed_next;
    logic             prompt_armed_reg, prompt_armed_next;
    cmot_pkg::timer_t idle_elapsed_reg, idle_elapsed_next;
    logic             idle_armed_reg, idle_armed_next;

    logic             is_digit;
    logic             is_space;
    logic             is_prompt;
    logic             char_ok;
    logic             send_sync;
    logic             timed_out;
    cmot_pkg::timer_t prompt_cnt;
    cmot_pkg::timer_t idle_cnt;

    // Character classes.
    assign is_digit  = (rx_char >= cmot_pkg::CH_ZERO) && (rx_char <= cmot_pkg::CH_SEVEN);
    assign is_space  = (rx_char == cmot_pkg::CH_SPACE) || (rx_char == cmot_pkg::CH_CR) ||
                       (rx_char == cmot_pkg::CH_LF);
    assign is_prompt = (rx_char == cmot_pkg::CH_AT) || (rx_char == cmot_pkg::CH_DOLLAR);

    // Saturating tick counts, used only on a tick.
    assign prompt_cnt = (prompt_armed_reg && (prompt_elapsed_reg != {cmot_pkg::TIMER_BITS{1'b1}}))
                      ? prompt_elapsed_reg + cmot_pkg::timer_t'(1) : prompt_elapsed_reg;
    assign idle_cnt   = (idle_armed_reg && (idle_elapsed_reg != {cmot_pkg::TIMER_BITS{1'b1}}))
                      ? idle_elapsed_reg + cmot_pkg::timer_t'(1) : idle_elapsed_reg;

    // The sync character is accepted only while synchronizing.
    assign char_ok = is_prompt || is_space || is_digit ||
                     (rx_char == cmot_pkg::CH_L) || (rx_char == cmot_pkg::CH_E) ||
                     (rx_char == cmot_pkg::CH_D) || (rx_char == cmot_pkg::CH_S) ||
                     ((rx_char == cfg.sync_char) &&
                      ((phase_reg == cmot_pkg::PH_WAIT_SYNC) ||
                       (phase_reg == cmot_pkg::PH_WAIT_INIT_PROMPT)));

    // Next-state logic for one transaction.
    always_comb
    begin
        phase_next          = phase_reg;
        cmd_next            = cmd_reg;
        addr_next           = addr_reg;
        addr_vld_next       = addr_vld_reg;
        value_next          = value_reg;
        digit_seen_next     = digit_seen_reg;
        prompt_elapsed_next = prompt_elapsed_reg;
        prompt_armed_next   = prompt_armed_reg;
        idle_elapsed_next   = idle_elapsed_reg;
        idle_armed_next     = idle_armed_reg;
        send_sync           = 1'b0;
        timed_out           = 1'b0;

        unique case (cmot_pkg::kind_t'(kind))
            cmot_pkg::KIND_CHAR:
            begin
                if (char_ok)
                begin
                    unique case (phase_reg)
                        cmot_pkg::PH_WAIT_SYNC:
                        begin
                            if (rx_char == cfg.sync_char)
                            begin
                                phase_next        = cmot_pkg::PH_WAIT_INIT_PROMPT;
                                idle_armed_next   = 1'b1;
                                idle_elapsed_next = '0;
                            end
                        end
                        cmot_pkg::PH_WAIT_INIT_PROMPT, cmot_pkg::PH_WAIT_PROMPT:
                        begin
                            if (phase_reg == cmot_pkg::PH_WAIT_INIT_PROMPT)
                            begin
                                idle_armed_next = 1'b0;
                            end
                            if (is_prompt)
                            begin
                                phase_next        = cmot_pkg::PH_READY;
                                prompt_armed_next = 1'b0;
                            end
                        end
                        cmot_pkg::PH_READY, cmot_pkg::PH_WAIT_RESP:
                        begin
                            // L, E and D echoes start parsing; S and others wait for a prompt.
                            priority if (rx_char == cmot_pkg::CH_L)
                            begin
                                cmd_next        = cmot_pkg::CMD_LOAD;
                                phase_next      = cmot_pkg::PH_PARSE_ADDR;
                                digit_seen_next = 1'b0;
                                addr_next       = '0;
                                addr_vld_next   = 1'b1;
                                value_next      = '0;
                            end
                            else if (rx_char == cmot_pkg::CH_E)
                            begin
                                cmd_next        = cmot_pkg::CMD_EXAM;
                                phase_next      = cmot_pkg::PH_PARSE_ADDR;
                                digit_seen_next = 1'b0;
                                addr_next       = '0;
                                addr_vld_next   = 1'b1;
                            end
                            else if (rx_char == cmot_pkg::CH_D)
                            begin
                                if ((cmd_reg == cmot_pkg::CMD_DEP) && addr_vld_reg)
                                begin
                                    addr_next = addr_reg + cmot_pkg::ADDR_STEP;
                                end
                                cmd_next        = cmot_pkg::CMD_DEP;
                                phase_next      = cmot_pkg::PH_PARSE_VAL;
                                digit_seen_next = 1'b0;
                                value_next      = '0;
                            end
                            else if (rx_char == cmot_pkg::CH_S)
                            begin
                                cmd_next      = cmot_pkg::CMD_START;
                                phase_next    = cmot_pkg::PH_WAIT_PROMPT;
                                addr_next     = '0;
                                addr_vld_next = 1'b0;
                                value_next    = '0;
                            end
                            else
                            begin
                                cmd_next   = cmot_pkg::CMD_NONE;
                                phase_next = cmot_pkg::PH_WAIT_PROMPT;
                            end
                            prompt_armed_next   = 1'b1;
                            prompt_elapsed_next = '0;
                        end
                        cmot_pkg::PH_PARSE_ADDR:
                        begin
                            priority if (is_digit)
                            begin
                                addr_next       = {addr_reg[cmot_pkg::ADDR_W-4:0], rx_char[2:0]};
                                addr_vld_next   = 1'b1;
                                digit_seen_next = 1'b1;
                            end
                            else if (is_space)
                            begin
                                if (digit_seen_reg)
                                begin
                                    if (cmd_reg == cmot_pkg::CMD_EXAM)
                                    begin
                                        phase_next = cmot_pkg::PH_PARSE_VAL;
                                        value_next = '0;
                                    end
                                    else
                                    begin
                                        phase_next = cmot_pkg::PH_WAIT_PROMPT;
                                    end
                                end
                            end
                            else
                            begin
                                phase_next    = cmot_pkg::PH_WAIT_PROMPT;
                                addr_next     = '0;
                                addr_vld_next = 1'b0;
                            end
                        end
                        cmot_pkg::PH_PARSE_VAL:
                        begin
                            priority if (is_digit)
                            begin
                                value_next      = {value_reg[cmot_pkg::ADDR_W-4:0], rx_char[2:0]};
                                digit_seen_next = 1'b1;
                            end
                            else if (is_space)
                            begin
                                if (digit_seen_reg)
                                begin
                                    phase_next = cmot_pkg::PH_WAIT_PROMPT;
                                end
                            end
                            else
                            begin
                                phase_next = cmot_pkg::PH_WAIT_PROMPT;
                            end
                        end
                        default:
                        begin
                            // Characters in the start phase change nothing.
                            phase_next = phase_reg;
                        end
                    endcase
                end
            end
            cmot_pkg::KIND_TICK:
            begin
                prompt_elapsed_next = prompt_cnt;
                idle_elapsed_next   = idle_cnt;
                if (phase_reg == cmot_pkg::PH_START)
                begin
                    send_sync           = 1'b1;
                    phase_next          = cmot_pkg::PH_WAIT_SYNC;
                    prompt_armed_next   = 1'b1;
                    prompt_elapsed_next = '0;
                end
                else if (phase_reg != cmot_pkg::PH_READY)
                begin
                    // The idle timeout asks for sync again and restarts its count.
                    if ((phase_reg == cmot_pkg::PH_WAIT_INIT_PROMPT) && idle_armed_reg &&
                        (cmot_pkg::cmp_t'(idle_cnt) >= cmot_pkg::cmp_t'(cfg.idle_timeout)))
                    begin
                        send_sync         = 1'b1;
                        idle_elapsed_next = '0;
                    end
                    if (prompt_armed_reg &&
                        (cmot_pkg::cmp_t'(prompt_cnt) >= cmot_pkg::cmp_t'(cfg.prompt_timeout)))
                    begin
                        timed_out = 1'b1;
                    end
                end
            end
            cmot_pkg::KIND_CMD_SENT:
            begin
                if (phase_reg == cmot_pkg::PH_READY)
                begin
                    phase_next = cmot_pkg::PH_WAIT_RESP;
                end
            end
            default:
            begin
                // Restart clears everything but the digit flag.
                phase_next          = cmot_pkg::PH_START;
                cmd_next            = cmot_pkg::CMD_NONE;
                addr_next           = '0;
                addr_vld_next       = 1'b0;
                value_next          = '0;
                prompt_elapsed_next = '0;
                prompt_armed_next   = 1'b0;
                idle_elapsed_next   = '0;
                idle_armed_next     = 1'b0;
            end
        endcase
    end

    // Result fields reflect the state after the update.
    always_comb
    begin
        result.char_ok       = (kind == cmot_pkg::KIND_CHAR) && char_ok;
        result.send_sync     = send_sync;
        result.timed_out     = timed_out;
        result.ready_res     = (phase_next == cmot_pkg::PH_READY);
        result.last_command  = cmd_next;
        result.last_address  = addr_vld_next ? addr_next : '0;
        result.address_known = addr_vld_next;
        result.last_value    = value_next;
    end

    // State registers advance once per processed transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= cmot_pkg::PH_START;
            cmd_reg            <= cmot_pkg::CMD_NONE;
            addr_reg           <= '0;
            addr_vld_reg       <= 1'b0;
            value_reg          <= '0;
            digit_seen_reg     <= 1'b0;
            prompt_elapsed_reg <= '0;
            prompt_armed_reg   <= 1'b0;
            idle_elapsed_reg   <= '0;
            idle_armed_reg     <= 1'b0;
        end
        else if (item_en)
        begin
            phase_reg          <= phase_next;
            cmd_reg            <= cmd_next;
            addr_reg           <= addr_next;
            addr_vld_reg       <= addr_vld_next;
            value_reg          <= value_next;
            digit_seen_reg     <= digit_seen_next;
            prompt_elapsed_reg <= prompt_elapsed_next;
            prompt_armed_reg   <= prompt_armed_next;
            idle_elapsed_reg   <= idle_elapsed_next;
            idle_armed_reg     <= idle_armed_next;
        end
    end

endmodule
